// ----- design/closest_ray_triangle_pick_core_macros.svh -----
// Assertion macros for the closest ray-triangle pick core.
`ifndef CLOSEST_RAY_TRIANGLE_PICK_CORE_MACROS_SVH
`define CLOSEST_RAY_TRIANGLE_PICK_CORE_MACROS_SVH
// Implication that must hold on every clock edge outside reset.
`define CRTP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Implication checked in the cycle after the antecedent.
`define CRTP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- design/crtp_pkg.sv -----
// Package with types, constants and the controller interface of the pick core.
`timescale 1ns / 1ps
package crtp_pkg;
  localparam int unsigned RegionCountDef = 512;
  localparam int unsigned FracBitsDef = 12;
  localparam int unsigned DistW = 24;
  localparam logic [DistW-1:0] DistMax = '1;

  localparam logic [2:0] RegOx = 3'd0;
  localparam logic [2:0] RegOy = 3'd1;
  localparam logic [2:0] RegOz = 3'd2;
  localparam logic [2:0] RegDx = 3'd3;
  localparam logic [2:0] RegDy = 3'd4;
  localparam logic [2:0] RegDz = 3'd5;

  typedef struct packed {
    logic signed [15:0] vert_a_x;
    logic signed [15:0] vert_a_y;
    logic signed [15:0] vert_a_z;
    logic signed [15:0] vert_b_x;
    logic signed [15:0] vert_b_y;
    logic signed [15:0] vert_b_z;
    logic signed [15:0] vert_c_x;
    logic signed [15:0] vert_c_y;
    logic signed [15:0] vert_c_z;
    logic [8:0]         region_id;
    logic               last_triangle;
  } in_beat_t;

  typedef struct packed {
    logic        hit_found;
    logic [8:0]  hit_region;
    logic [23:0] hit_distance;
  } out_beat_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_EDGE, ST_CROSS, ST_DOT, ST_SIGN, ST_CHECK, ST_DIV, ST_UPDATE, ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic edge_en;
    logic cross_en;
    logic dot_en;
    logic sign_en;
    logic check_en;
    logic div_step;
    logic update;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic candidate;
    logic div_done;
    logic last;
  } status_t;
endpackage

// ----- design/crtp_ctrl.sv -----
// Controller state machine that sequences one triangle through the datapath.
`timescale 1ns / 1ps
module crtp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  crtp_pkg::status_t status,
  output crtp_pkg::cmd_t    cmd
);
  crtp_pkg::state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= crtp_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_stall = 1'b1;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      crtp_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = crtp_pkg::ST_EDGE;
        end
      end
      crtp_pkg::ST_EDGE: begin
        cmd.edge_en = 1'b1;
        state_nxt = crtp_pkg::ST_CROSS;
      end
      crtp_pkg::ST_CROSS: begin
        cmd.cross_en = 1'b1;
        state_nxt = crtp_pkg::ST_DOT;
      end
      crtp_pkg::ST_DOT: begin
        cmd.dot_en = 1'b1;
        state_nxt = crtp_pkg::ST_SIGN;
      end
      crtp_pkg::ST_SIGN: begin
        cmd.sign_en = 1'b1;
        state_nxt = crtp_pkg::ST_CHECK;
      end
      crtp_pkg::ST_CHECK: begin
        cmd.check_en = 1'b1;
        state_nxt = crtp_pkg::ST_DIV;
      end
      crtp_pkg::ST_DIV: begin
        if (!status.candidate) begin
          state_nxt = crtp_pkg::ST_EMIT;
        end else if (status.div_done) begin
          state_nxt = crtp_pkg::ST_UPDATE;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      crtp_pkg::ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt = crtp_pkg::ST_EMIT;
      end
      crtp_pkg::ST_EMIT: begin
        if (!status.last) begin
          state_nxt = crtp_pkg::ST_IDLE;
        end else if (!out_valid_r || !out_stall) begin
          cmd.emit = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt = crtp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = crtp_pkg::ST_IDLE;
    endcase
  end
endmodule

// ----- design/crtp_dp.sv -----
// Datapath: Moller-Trumbore arithmetic, restoring divider and closest-hit store.
`timescale 1ns / 1ps
module crtp_dp #(
  parameter int unsigned REGION_COUNT = crtp_pkg::RegionCountDef,
  parameter int unsigned FRAC_BITS = crtp_pkg::FracBitsDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_idx,
  input  logic [15:0]         cfg_data,
  input  crtp_pkg::in_beat_t  in_beat,
  input  crtp_pkg::cmd_t      cmd,
  output crtp_pkg::status_t   status,
  output crtp_pkg::out_beat_t out_beat
);
  localparam longint unsigned DetEps = (64'd1 << (3 * FRAC_BITS)) / 64'd1000000;
  localparam int unsigned DivSteps = 24;
  localparam int unsigned CntW = $clog2(DivSteps + 1);

  logic signed [15:0] reg_r [6];
  crtp_pkg::in_beat_t tri_r;
  logic signed [16:0] e1_r [3], e2_r [3], s_r [3];
  logic signed [34:0] h_r [3], q_r [3];
  logic signed [53:0] det_r, u_r, v_r, t_r;
  logic cand_r;
  logic [52:0] rem_r, den_r;
  logic [DivSteps-1:0] quo_r;
  logic [CntW-1:0] cnt_r;
  logic [23:0] best_dist_r;
  logic [8:0] best_reg_r;
  logic any_hit_r;
  crtp_pkg::out_beat_t out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reg_r[crtp_pkg::RegOx] <= '0;
      reg_r[crtp_pkg::RegOy] <= '0;
      reg_r[crtp_pkg::RegOz] <= '0;
      reg_r[crtp_pkg::RegDx] <= '0;
      reg_r[crtp_pkg::RegDy] <= '0;
      reg_r[crtp_pkg::RegDz] <= 16'sd4096;
    end else if (cfg_we) begin
      reg_r[cfg_idx] <= cfg_data;
    end
  end

  // Sign-extended products, summed before the result is registered.
  function automatic logic signed [34:0] mul17(logic signed [16:0] a, logic signed [16:0] b);
    mul17 = 35'(a * b);
  endfunction

  logic signed [16:0] dv [3], ov [3], av [3], bv [3], cv [3];
  always_comb begin
    ov[0] = 17'(reg_r[crtp_pkg::RegOx]); ov[1] = 17'(reg_r[crtp_pkg::RegOy]);
    ov[2] = 17'(reg_r[crtp_pkg::RegOz]);
    dv[0] = 17'(reg_r[crtp_pkg::RegDx]); dv[1] = 17'(reg_r[crtp_pkg::RegDy]);
    dv[2] = 17'(reg_r[crtp_pkg::RegDz]);
    av[0] = 17'(tri_r.vert_a_x); av[1] = 17'(tri_r.vert_a_y); av[2] = 17'(tri_r.vert_a_z);
    bv[0] = 17'(tri_r.vert_b_x); bv[1] = 17'(tri_r.vert_b_y); bv[2] = 17'(tri_r.vert_b_z);
    cv[0] = 17'(tri_r.vert_c_x); cv[1] = 17'(tri_r.vert_c_y); cv[2] = 17'(tri_r.vert_c_z);
  end

  // Three-term dot-product sums over 17x35 factors: h and q are 35 bits,
  // so each dot term is a 17x35 product, fine at this size.
  function automatic logic signed [53:0] dot3(
    logic signed [16:0] a0, logic signed [16:0] a1, logic signed [16:0] a2,
    logic signed [34:0] b0, logic signed [34:0] b1, logic signed [34:0] b2);
    logic signed [53:0] p0, p1, p2;
    p0 = 54'(a0) * 54'(b0);
    p1 = 54'(a1) * 54'(b1);
    p2 = 54'(a2) * 54'(b2);
    dot3 = p0 + p1 + p2;
  endfunction

  logic det_neg;
  logic signed [53:0] uv_sum;
  logic [53:0] nxt_rem;
  logic [61:0] den_wide;
  always_comb begin
    det_neg = det_r[53];
    uv_sum = u_r + v_r;
    nxt_rem = {rem_r, 1'b0};
    den_wide = {9'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (cmd.load) tri_r <= in_beat;
    if (cmd.edge_en) begin
      for (int i = 0; i < 3; i++) begin
        e1_r[i] <= bv[i] - av[i];
        e2_r[i] <= cv[i] - av[i];
        s_r[i] <= ov[i] - av[i];
      end
    end
    if (cmd.cross_en) begin
      h_r[0] <= mul17(dv[1], e2_r[2]) - mul17(dv[2], e2_r[1]);
      h_r[1] <= mul17(dv[2], e2_r[0]) - mul17(dv[0], e2_r[2]);
      h_r[2] <= mul17(dv[0], e2_r[1]) - mul17(dv[1], e2_r[0]);
      q_r[0] <= mul17(s_r[1], e1_r[2]) - mul17(s_r[2], e1_r[1]);
      q_r[1] <= mul17(s_r[2], e1_r[0]) - mul17(s_r[0], e1_r[2]);
      q_r[2] <= mul17(s_r[0], e1_r[1]) - mul17(s_r[1], e1_r[0]);
    end
    if (cmd.dot_en) begin
      det_r <= dot3(e1_r[0], e1_r[1], e1_r[2], h_r[0], h_r[1], h_r[2]);
      u_r <= dot3(s_r[0], s_r[1], s_r[2], h_r[0], h_r[1], h_r[2]);
      v_r <= dot3(dv[0], dv[1], dv[2], q_r[0], q_r[1], q_r[2]);
      t_r <= dot3(e2_r[0], e2_r[1], e2_r[2], q_r[0], q_r[1], q_r[2]);
    end
    if (cmd.sign_en && det_neg) begin
      det_r <= -det_r;
      u_r <= -u_r;
      v_r <= -v_r;
      t_r <= -t_r;
    end
    if (cmd.check_en) begin
      cand_r <= (32'(tri_r.region_id) < REGION_COUNT) && (det_r != 0) &&
                (det_r >= $signed(54'(DetEps))) && !u_r[53] && (u_r <= det_r) &&
                !v_r[53] && (uv_sum <= det_r) && !t_r[53] && (t_r != 0);
      // Quotient is taken 24 bits wide from T scaled by 2^16; bits above
      // bit 23 of the quotient are tested first by comparing T to det<<8.
      rem_r <= 53'(t_r);
      den_r <= 53'(det_r);
      quo_r <= '0;
      cnt_r <= '0;
    end
    if (cmd.div_step) begin
      // restoring division of T*2^16 by det, one quotient bit per cycle;
      // the first step gives no bit and flags an integer part of 256 or more
      if (cnt_r == '0) begin
        if ({9'b0, t_r[52:0]} >= (den_wide << 8)) begin
          quo_r <= crtp_pkg::DistMax;
          cnt_r <= CntW'(DivSteps);
        end else begin
          rem_r <= 53'(t_r);
          cnt_r <= cnt_r + 1'b1;
        end
      end else begin
        quo_r <= quo_r;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r <= CntW'(8)) begin
          // integer bits: compare rem with den shifted by the bit weight
          if ({9'b0, rem_r} >= (den_wide << (4'd8 - 4'(cnt_r)))) begin
            rem_r <= 53'({9'b0, rem_r} - (den_wide << (4'd8 - 4'(cnt_r))));
            quo_r[CntW'(DivSteps - 32'(cnt_r))] <= 1'b1;
          end
        end else begin
          if (nxt_rem >= {1'b0, den_r}) begin
            rem_r <= 53'(nxt_rem - {1'b0, den_r});
            quo_r[CntW'(DivSteps - 32'(cnt_r))] <= 1'b1;
          end else begin
            rem_r <= nxt_rem[52:0];
          end
        end
      end
    end
  end

  assign status.candidate = cand_r;
  assign status.div_done = (cnt_r == CntW'(DivSteps + 1)) ||
                           (cnt_r == CntW'(DivSteps) && quo_r == crtp_pkg::DistMax);
  assign status.last = tri_r.last_triangle;

  logic upd_ok;
  assign upd_ok = (quo_r != '0) && (!any_hit_r || quo_r < best_dist_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_dist_r <= crtp_pkg::DistMax;
      best_reg_r <= '0;
      any_hit_r <= 1'b0;
    end else if (cmd.emit) begin
      best_dist_r <= crtp_pkg::DistMax;
      best_reg_r <= '0;
      any_hit_r <= 1'b0;
    end else if (cmd.update && upd_ok) begin
      best_dist_r <= quo_r;
      best_reg_r <= tri_r.region_id;
      any_hit_r <= 1'b1;
    end
    if (cmd.emit) begin
      out_r.hit_found <= any_hit_r;
      out_r.hit_region <= any_hit_r ? best_reg_r : '0;
      out_r.hit_distance <= any_hit_r ? best_dist_r : '0;
    end
  end

  assign out_beat = out_r;
endmodule

// ----- design/closest_ray_triangle_pick_core.sv -----
// Top level of the closest ray-triangle pick core.
//   channel  direction  handshake           beat
//   in_      input      in_valid/in_stall   one triangle
//   out_     output     out_valid/out_stall one pick result
//   cfg_     input      cfg_valid/cfg_ready one ray register write
// Each triangle runs the load, edge, cross, dot, sign, check, divide, update and
// emit steps before the next beat is accepted; one that cannot hit skips divide
// and update; the divider stops after its range step if t saturates, else 24 bits.
// Reset is synchronous and active low; it loads the default ray.
// A waiting result only holds back the final triangle's emit step.
`timescale 1ns / 1ps
`include "closest_ray_triangle_pick_core_macros.svh"
module closest_ray_triangle_pick_core #(
  parameter int unsigned REGION_COUNT = crtp_pkg::RegionCountDef,
  parameter int unsigned FRAC_BITS = crtp_pkg::FracBitsDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  crtp_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output crtp_pkg::out_beat_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data
);
  crtp_pkg::cmd_t cmd;
  crtp_pkg::status_t status;
  logic cfg_we;

  // Writes beyond the last register are accepted and dropped.
  assign cfg_ready = 1'b1;
  assign cfg_we = cfg_valid && (cfg_index <= crtp_pkg::RegDz);

  crtp_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .status(status), .cmd(cmd)
  );

  crtp_dp #(.REGION_COUNT(REGION_COUNT), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_index), .cfg_data(cfg_data),
    .in_beat(in_data), .cmd(cmd), .status(status), .out_beat(out_data)
  );

  `CRTP_ASSERT_IMP(a_no_hit_zero, clk, rst_n, out_valid && !out_data.hit_found, out_data.hit_distance == '0, "miss with distance")
  `CRTP_ASSERT_NEXT(a_emit_valid, clk, rst_n, cmd.emit, out_valid, "emit lost")
  `CRTP_ASSERT_IMP(a_emit_onehot, clk, rst_n, 1'b1, $onehot0({cmd.load, cmd.emit, cmd.update}), "command clash")
endmodule
